// ----- rtl/core/tccd_pkg.sv -----
// ----------------------------------------------------------------------------
// tccd_pkg
// Shared types and constants of the channel command decoder: byte code
// boundaries, event kinds, per-channel state and the event record.
// ----------------------------------------------------------------------------
package tccd_pkg;

    // Channel count default and fixed field widths
    localparam int NUM_CHANNELS_DEF = 3;
    localparam int CHAN_W           = 2;
    localparam int BYTE_W           = 8;
    localparam int KIND_W           = 4;
    localparam int VALUE_W          = 7;
    localparam int SHAPE_W          = 4;
    localparam int AMOUNT_W         = 12;
    localparam int PERIOD_W         = 7;
    localparam int NOTE_W           = 8;

    // Byte code boundaries of the command stream
    localparam logic [BYTE_W-1:0] B_NOTE_MAX    = 8'h5f;
    localparam logic [BYTE_W-1:0] B_REST        = 8'h60;
    localparam logic [BYTE_W-1:0] B_SAMPLE_BASE = 8'h61;
    localparam logic [BYTE_W-1:0] B_SAMPLE_MAX  = 8'h6f;
    localparam logic [BYTE_W-1:0] B_ORN_BASE    = 8'h70;
    localparam logic [BYTE_W-1:0] B_ORN_MAX     = 8'h8f;
    localparam logic [BYTE_W-1:0] B_EMPTY       = 8'h90;
    localparam logic [BYTE_W-1:0] B_VOL_MAX     = 8'h9f;
    localparam logic [BYTE_W-1:0] B_ORN_OFF     = 8'ha0;
    localparam logic [BYTE_W-1:0] B_ENV_BASE    = 8'ha1;
    localparam logic [BYTE_W-1:0] B_ENV_MAX     = 8'hb0;
    localparam logic [BYTE_W-1:0] B_TONE_SHAPE  = 8'ha9;
    localparam logic [BYTE_W-1:0] B_TONE_MAX    = 8'hb7;
    localparam logic [BYTE_W-1:0] B_PERIOD_BASE = 8'hb8;
    localparam logic [BYTE_W-1:0] B_PERIOD_MAX  = 8'hf8;
    localparam logic [BYTE_W-1:0] B_PAD         = 8'hf9;
    localparam logic [BYTE_W-1:0] B_REINIT_ON   = 8'hfb;
    localparam logic [BYTE_W-1:0] B_TONE_HIGH   = 8'hf1;
    localparam logic [NOTE_W-1:0] NOTE_WRAP     = 8'h60;
    localparam logic [NOTE_W-1:0] NOTE_RESET    = 8'd48;

    // Input item kinds
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        EV_NOTE      = 4'd0,
        EV_REST      = 4'd1,
        EV_EMPTY     = 4'd2,
        EV_SAMPLE    = 4'd3,
        EV_ORNAMENT  = 4'd4,
        EV_VOLUME    = 4'd5,
        EV_ORN_OFF   = 4'd6,
        EV_ENV_NOTE  = 4'd7,
        EV_ENV_TONE  = 4'd8,
        EV_REINIT    = 4'd9,
        EV_END       = 4'd10
    } event_kind_t;

    typedef struct packed {
        logic [NOTE_W-1:0]   note;
        logic [PERIOD_W-1:0] period;
        logic                pending;
        logic [SHAPE_W-1:0]  shape;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        note:    NOTE_RESET,
        period:  '0,
        pending: 1'b0,
        shape:   '0
    };

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        event_kind_t         kind;
        logic [VALUE_W-1:0]  value;
        logic                rest;
        logic [SHAPE_W-1:0]  shape;
        logic [AMOUNT_W-1:0] amount;
        logic                done;
        logic [PERIOD_W-1:0] hold;
    } event_t;

endpackage

// ----- rtl/core/tracker_channel_command_decoder_core.sv -----
// ----------------------------------------------------------------------------
// tracker_channel_command_decoder_core
// Turns the command bytes of several pattern channels into note, effect,
// envelope and row events, keeping each channel's running note, row period
// and pending envelope-tone command.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle unless an event in the input register waits
// for a full result register. An item goes through an input register, is
// decoded combinationally against its channel's state, and its event, if any,
// lands in the result register, which drives tvalid on the output. The
// per-channel state is updated in the decode cycle, so items of the same
// channel may follow each other directly. Restart items, period bytes, padding,
// first envelope-tone bytes and bytes of a channel beyond the configured count
// produce no event and leave nothing on the output. The input side keeps
// accepting while a result waits, as long as the waiting result is not blocking
// an event in the input register.
module tracker_channel_command_decoder_core #(
    parameter int NUM_CHANNELS = tccd_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] chan, [9:2] data_byte, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] chan_out, [8:2] event_value, [9] rest_flag, [13:10] env_shape,
    // [25:14] env_amount, [32:26] hold_rows, [39:33] zero
    output logic [39:0] m_axis_tdata,
    // [3:0] event_kind
    output logic [3:0]  m_axis_tuser,
    // row_done
    output logic        m_axis_tlast
);
    import tccd_pkg::*;

    logic                in_valid_reg;
    logic                in_cmd_reg;
    logic [CHAN_W-1:0]   in_chan_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                out_valid_reg;
    event_t              out_ev_reg;
    chan_state_t         state_reg [NUM_CHANNELS];

    chan_state_t         state_cur;
    chan_state_t         state_next;
    logic                dec_valid;
    event_t              dec_ev;
    logic                in_range;
    logic                ev_emit;
    logic                out_slot;
    logic                fire;
    logic                in_take;

    // Select the state of the addressed channel
    always_comb
    begin
        state_cur = CHAN_RESET;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (int'(in_chan_reg) == i)
            begin
                state_cur = state_reg[i];
            end
        end
    end

    tccd_decode u_decode (
        .cmd        (in_cmd_reg),
        .chan       (in_chan_reg),
        .data_byte  (in_byte_reg),
        .state_cur  (state_cur),
        .state_next (state_next),
        .ev_valid   (dec_valid),
        .ev         (dec_ev)
    );

    // Flow control between input register and result register
    assign in_range      = int'(in_chan_reg) < NUM_CHANNELS;
    assign ev_emit       = dec_valid && in_range;
    assign out_slot      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && (!ev_emit || out_slot);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !in_valid_reg || fire;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_chan_reg <= s_axis_tdata[1:0];
            in_byte_reg <= s_axis_tdata[9:2];
        end
    end

    // Per-channel state: update the addressed channel as its item is decoded
    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                state_reg[g] <= CHAN_RESET;
            end
            else if (fire && in_range && int'(in_chan_reg) == g)
            begin
                state_reg[g] <= state_next;
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_slot)
        begin
            out_valid_reg <= fire && ev_emit;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_slot && fire && ev_emit)
        begin
            out_ev_reg <= dec_ev;
        end
    end

    // Pack the result item
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ev_reg.kind;
    assign m_axis_tlast  = out_ev_reg.done;
    assign m_axis_tdata  = {7'b0, out_ev_reg.hold, out_ev_reg.amount, out_ev_reg.shape,
                            out_ev_reg.rest, out_ev_reg.value, out_ev_reg.chan};

    // Row-ending events are exactly note, rest, empty row and end
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (out_ev_reg.kind == EV_NOTE
            || out_ev_reg.kind == EV_REST || out_ev_reg.kind == EV_EMPTY
            || out_ev_reg.kind == EV_END)))
        else $error("row_done does not match event kind");

    // A hold count is only given with a row-ending event
    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (out_ev_reg.hold == '0))
        else $error("hold_rows set on a non row-ending event");

    // Envelope shape appears only on envelope events
    a_shape_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_ev_reg.shape != '0) |->
            (out_ev_reg.kind == EV_ENV_NOTE || out_ev_reg.kind == EV_ENV_TONE))
        else $error("env_shape set on a non-envelope event");

    // A new result is loaded only from a decoded item
    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a decoded item");

endmodule

// ----- rtl/core/tccd_decode.sv -----
// ----------------------------------------------------------------------------
// tccd_decode
// Combinational decode of one command byte against the state of its channel:
// gives at most one event and the channel's next state.
// ----------------------------------------------------------------------------
module tccd_decode (
    input  logic                          cmd,
    input  logic [tccd_pkg::CHAN_W-1:0]   chan,
    input  logic [tccd_pkg::BYTE_W-1:0]   data_byte,
    input  tccd_pkg::chan_state_t         state_cur,
    output tccd_pkg::chan_state_t         state_next,
    output logic                          ev_valid,
    output tccd_pkg::event_t              ev
);
    import tccd_pkg::*;

    logic [NOTE_W-1:0]  note_sub;
    logic [NOTE_W-1:0]  note_wrap;
    logic [NOTE_W-1:0]  note_new;
    logic [BYTE_W-1:0]  env_p;
    logic [AMOUNT_W-1:0] tone_amt;

    // Note arithmetic: subtract, wrap by 96 when it would go below zero
    assign note_sub  = state_cur.note - data_byte;
    assign note_wrap = state_cur.note + NOTE_WRAP - data_byte;
    assign note_new  = (state_cur.note >= data_byte) ? note_sub : note_wrap;

    // Operands of the envelope commands
    assign env_p    = data_byte - B_ENV_BASE;
    assign tone_amt = (data_byte >= B_TONE_HIGH) ? {data_byte[3:0], 8'h00}
                                                 : {4'h0, data_byte};

    // Decode the byte
    always_comb
    begin
        state_next = state_cur;
        ev_valid   = 1'b1;
        ev         = '0;
        ev.chan    = chan;
        ev.kind    = EV_NOTE;

        priority if (cmd == CMD_RESTART)
        begin
            state_next = CHAN_RESET;
            ev_valid   = 1'b0;
        end
        else if (state_cur.pending)
        begin
            state_next.pending = 1'b0;
            ev.kind            = EV_ENV_TONE;
            ev.shape           = state_cur.shape;
            ev.amount          = tone_amt;
        end
        else if (data_byte <= B_NOTE_MAX)
        begin
            state_next.note = note_new;
            ev.kind         = EV_NOTE;
            ev.value        = note_new[VALUE_W-1:0];
            ev.rest         = note_new[NOTE_W-1];
            ev.done         = 1'b1;
        end
        else if (data_byte == B_REST)
        begin
            ev.kind = EV_REST;
            ev.done = 1'b1;
        end
        else if (data_byte <= B_SAMPLE_MAX)
        begin
            ev.kind  = EV_SAMPLE;
            ev.value = VALUE_W'(data_byte - B_SAMPLE_BASE);
        end
        else if (data_byte <= B_ORN_MAX)
        begin
            ev.kind  = EV_ORNAMENT;
            ev.value = VALUE_W'(data_byte - B_ORN_BASE);
        end
        else if (data_byte == B_EMPTY)
        begin
            ev.kind = EV_EMPTY;
            ev.done = 1'b1;
        end
        else if (data_byte <= B_VOL_MAX)
        begin
            ev.kind  = EV_VOLUME;
            ev.value = VALUE_W'(data_byte - B_EMPTY);
        end
        else if (data_byte == B_ORN_OFF)
        begin
            ev.kind = EV_ORN_OFF;
        end
        else if (data_byte <= B_ENV_MAX)
        begin
            ev.kind   = EV_ENV_NOTE;
            ev.shape  = {1'b1, env_p[1:0], 1'b0};
            ev.amount = AMOUNT_W'(env_p[3:2]) * AMOUNT_W'(12);
        end
        else if (data_byte <= B_TONE_MAX)
        begin
            // First envelope-tone byte: keep the shape, wait for the operand
            state_next.shape   = SHAPE_W'(data_byte - B_TONE_SHAPE);
            state_next.pending = 1'b1;
            ev_valid           = 1'b0;
        end
        else if (data_byte <= B_PERIOD_MAX)
        begin
            state_next.period = PERIOD_W'(data_byte - B_PERIOD_BASE);
            ev_valid          = 1'b0;
        end
        else if (data_byte == B_PAD)
        begin
            ev_valid = 1'b0;
        end
        else if (data_byte <= B_REINIT_ON)
        begin
            ev.kind  = EV_REINIT;
            ev.value = VALUE_W'(data_byte == B_REINIT_ON);
        end
        else
        begin
            ev.kind = EV_END;
            ev.done = 1'b1;
        end

        // Row-ending events carry the period in force
        ev.hold = ev.done ? state_cur.period : '0;
    end

endmodule
